// File: rtl/core/rational_arith_unit_core_defines.svh
// Assertion macros for the rational arithmetic core.
`ifndef RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst_n, prop, msg)
`define RAU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/rau_pkg.sv
package rau_pkg;

    localparam int WordBits = 32;
    localparam int WideBits = 2 * WordBits;
    localparam int GcdCntBits = $clog2(WideBits + 1);

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_NORM = 3'd0;
    localparam cmd_t CMD_ADD  = 3'd1;
    localparam cmd_t CMD_SUB  = 3'd2;
    localparam cmd_t CMD_MUL  = 3'd3;
    localparam cmd_t CMD_DIV  = 3'd4;
    localparam cmd_t CMD_CMP  = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_ZERO_DEN = 2'd1;
    localparam status_t ST_DIV_ZERO = 2'd2;
    localparam status_t ST_OVERFLOW = 2'd3;

    typedef logic [WideBits-1:0] wide_t;

    // Control between the sequencer and the divider.
    typedef struct packed {
        logic start;
        wide_t dividend;
        wide_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        wide_t quotient;
        wide_t remainder;
    } div_rsp_t;

endpackage

// File: rtl/core/rau_divider.sv
module rau_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t rsp
);
    import rau_pkg::*;

    // Restoring divider, one quotient bit per cycle.
    logic                  busy_reg, busy_next;
    logic [GcdCntBits-1:0] cnt_reg, cnt_next;
    wide_t                 quo_reg, quo_next;
    wide_t                 rem_reg, rem_next;
    wide_t                 dvs_reg, dvs_next;
    logic                  done_reg, done_next;
    logic [WideBits:0]     trial;
    logic [WideBits:0]     shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WideBits-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = GcdCntBits'(WideBits);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[WideBits])
            begin
                rem_next = trial[WideBits-1:0];
                quo_next = {quo_reg[WideBits-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WideBits-1:0];
                quo_next = {quo_reg[WideBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == GcdCntBits'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/core/rational_arith_unit_core.sv
// Rational arithmetic core: one command at a time through a shared multiplier and divider.
// Sequence: check the operands, form the cross products in the shared multiplier (not for
// normalize), run Euclid's gcd of the 64-bit magnitude and denominator on the divider, divide
// both by the gcd (skipped for a zero result), check the range and load the output.
// Throughput: the next transfer is taken in the cycle after the result register is loaded.
// Reset: asynchronous, active low; clears the sequencer, the output valid and the output.
`include "rational_arith_unit_core_defines.svh"
module rational_arith_unit_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // command[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
    input  logic [135:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // res_num[31:0], res_den[62:32], status[64:63], is_less[65], is_equal[66],
    // is_greater[67], zero fill
    output logic [71:0]   m_tdata
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL1, S_MUL2, S_ADD, S_GCD_START, S_GCD_WAIT,
        S_RED_NUM, S_RED_NUM_WAIT, S_RED_DEN_WAIT, S_CHECK, S_OUT
    } state_t;

    localparam logic [WordBits-1:0] Half = {1'b1, {(WordBits-1){1'b0}}};

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [WordBits-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic                 aneg_reg, bneg_reg, neg_reg;
    wide_t                p1_reg, p2_reg, mag_reg, den_reg, gx_reg, gy_reg, g_reg;
    logic [71:0]          out_reg;
    logic [71:0]          out_next;
    logic                 ovalid_reg;
    div_req_t             dreq;
    div_rsp_t             drsp;
    status_t              st_reg;
    logic                 sign_b;
    logic [WordBits-1:0]  mul_x, mul_y;
    wide_t                mul_p;
    logic [2:0]           mul_sel;
    logic                 ovf;

    function automatic logic [WordBits-1:0] mag_of(input logic [WordBits-1:0] v);
        mag_of = v[WordBits-1] ? (~v + 1'b1) : v;
    endfunction

    rau_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // One shared 32x32 multiplier.
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        case (state_reg)
            S_MUL1:
            begin
                mul_x = an_reg;
                mul_y = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            S_MUL2:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
                if (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV)
                begin
                    mul_x = ad_reg;
                    mul_y = (cmd_reg == CMD_MUL) ? bd_reg : bn_reg;
                end
            end
            S_ADD:
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
        mul_p = WideBits'(mul_x) * WideBits'(mul_y);
    end

    assign mul_sel = cmd_reg;
    assign sign_b  = (mul_sel == CMD_ADD) ? bneg_reg : (!bneg_reg && bn_reg != '0);
    assign ovf = (den_reg > WideBits'(Half - 1'b1)) ||
                 (mag_reg > (neg_reg ? WideBits'(Half) : WideBits'(Half - 1'b1)));

    always_comb
    begin
        out_next = '0;
        out_next[62:32] = 31'd1;
        out_next[64:63] = st_reg;
        if (st_reg == ST_OK && cmd_reg == CMD_CMP)
        begin
            out_next[65] = (mag_reg != '0) && neg_reg;
            out_next[66] = (mag_reg == '0);
            out_next[67] = (mag_reg != '0) && !neg_reg;
        end
        else if (st_reg == ST_OK && cmd_reg <= CMD_DIV)
        begin
            if (ovf)
                out_next[64:63] = ST_OVERFLOW;
            else
            begin
                out_next[31:0]  = neg_reg ? (~mag_reg[31:0] + 1'b1) : mag_reg[31:0];
                out_next[62:32] = den_reg[30:0];
            end
        end
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = gx_reg;
        dreq.divisor  = gy_reg;
        case (state_reg)
            S_GCD_START: dreq.start = (gy_reg != '0);
            S_RED_NUM:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = mag_reg;
                dreq.divisor  = g_reg;
            end
            S_RED_NUM_WAIT:
            begin
                dreq.start    = drsp.done;
                dreq.dividend = den_reg;
                dreq.divisor  = g_reg;
            end
            default: dreq.start = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                        state_reg <= S_PREP;
                S_PREP:
                begin
                    if (cmd_reg > CMD_CMP)
                        state_reg <= S_OUT;
                    else if (ad_reg == '0 || (cmd_reg != CMD_NORM && bd_reg == '0))
                        state_reg <= S_OUT;
                    else if (cmd_reg == CMD_DIV && bn_reg == '0)
                        state_reg <= S_OUT;
                    else if (cmd_reg == CMD_NORM)
                        state_reg <= S_GCD_START;
                    else
                        state_reg <= S_MUL1;
                end
                S_MUL1: state_reg <= S_MUL2;
                S_MUL2: state_reg <= S_ADD;
                S_ADD: state_reg <= S_GCD_START;
                S_GCD_START:
                    if (gy_reg == '0)
                        state_reg <= (mag_reg == '0) ? S_CHECK : S_RED_NUM;
                    else
                        state_reg <= S_GCD_WAIT;
                S_GCD_WAIT:
                    if (drsp.done)
                        state_reg <= S_GCD_START;
                S_RED_NUM: state_reg <= S_RED_NUM_WAIT;
                S_RED_NUM_WAIT:
                    if (drsp.done)
                        state_reg <= S_RED_DEN_WAIT;
                S_RED_DEN_WAIT:
                    if (drsp.done)
                        state_reg <= S_CHECK;
                S_CHECK: state_reg <= S_OUT;
                S_OUT:
                    if (!ovalid_reg || m_tready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_OUT && (!ovalid_reg || m_tready))
            begin
                ovalid_reg <= 1'b1;
                out_reg    <= out_next;
            end
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= s_tdata[2:0];
                an_reg   <= mag_of(s_tdata[34:3]);
                ad_reg   <= mag_of(s_tdata[66:35]);
                bn_reg   <= mag_of(s_tdata[98:67]);
                bd_reg   <= mag_of(s_tdata[130:99]);
                aneg_reg <= (s_tdata[34] != s_tdata[66]) && (s_tdata[34:3] != '0);
                bneg_reg <= (s_tdata[98] != s_tdata[130]) && (s_tdata[98:67] != '0);
                st_reg   <= ST_OK;
            end
            S_PREP:
            begin
                if (cmd_reg > CMD_CMP)
                    st_reg <= ST_OK;
                else if (ad_reg == '0 || (cmd_reg != CMD_NORM && bd_reg == '0))
                    st_reg <= ST_ZERO_DEN;
                else if (cmd_reg == CMD_DIV && bn_reg == '0)
                    st_reg <= ST_DIV_ZERO;
                mag_reg <= WideBits'(an_reg);
                den_reg <= WideBits'(ad_reg);
                neg_reg <= aneg_reg;
                gx_reg  <= WideBits'(an_reg);
                gy_reg  <= WideBits'(ad_reg);
            end
            S_MUL1: p1_reg <= mul_p;
            S_MUL2: p2_reg <= mul_p;
            S_ADD:
            begin
                if (cmd_reg == CMD_MUL || cmd_reg == CMD_DIV)
                begin
                    mag_reg <= p1_reg;
                    den_reg <= p2_reg;
                    neg_reg <= aneg_reg != bneg_reg;
                    gx_reg  <= p1_reg;
                    gy_reg  <= p2_reg;
                end
                else
                begin
                    // The shared multiplier forms the denominator product in this cycle.
                    den_reg <= mul_p;
                    gy_reg  <= mul_p;
                    if (aneg_reg == sign_b)
                    begin
                        mag_reg <= p1_reg + p2_reg;
                        gx_reg  <= p1_reg + p2_reg;
                        neg_reg <= aneg_reg && (p1_reg + p2_reg != '0);
                    end
                    else if (p1_reg >= p2_reg)
                    begin
                        mag_reg <= p1_reg - p2_reg;
                        gx_reg  <= p1_reg - p2_reg;
                        neg_reg <= aneg_reg && (p1_reg != p2_reg);
                    end
                    else
                    begin
                        mag_reg <= p2_reg - p1_reg;
                        gx_reg  <= p2_reg - p1_reg;
                        neg_reg <= sign_b;
                    end
                end
            end
            S_GCD_START:
                if (gy_reg == '0)
                    g_reg <= gx_reg;
            S_GCD_WAIT:
                if (drsp.done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= drsp.remainder;
                end
            S_RED_NUM_WAIT:
                if (drsp.done)
                    mag_reg <= drsp.quotient;
            S_RED_DEN_WAIT:
                if (drsp.done)
                    den_reg <= drsp.quotient;
            S_CHECK:
                if (mag_reg == '0)
                begin
                    neg_reg <= 1'b0;
                    den_reg <= WideBits'(1);
                end
            default: ;
        endcase
    end

    `RAU_ASSERT(a_busy_not_ready, clk, rst_n, (state_reg != S_IDLE) |-> !s_tready, "busy")
    `RAU_ASSERT(a_hold_out, clk, rst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata), "hold")
    `RAU_ASSERT(a_den_pos, clk, rst_n, m_tvalid |-> (m_tdata[62:32] != '0), "zero den")
    `RAU_ASSERT(a_flags, clk, rst_n, m_tvalid |-> $onehot0(m_tdata[67:65]), "flags")

endmodule

// File: verif/rational_arith_unit_core_tb.sv
`timescale 1ns / 1ps

module rational_arith_unit_core_tb;
    import rau_pkg::*;

    // Command codes with no operation behind them.
    localparam cmd_t CMD_RSVD_LO = 3'd6;
    localparam cmd_t CMD_RSVD_HI = 3'd7;

    class rational_scoreboard;
        logic [71:0] pending_results[$];
        int          mismatches;

        // Exact rational arithmetic on 64-bit magnitudes, then gcd reduction.
        function automatic logic [71:0] compute_result(cmd_t cmd, logic signed [31:0] an,
                                                       logic signed [31:0] ad,
                                                       logic signed [31:0] bn,
                                                       logic signed [31:0] bd);
            longint signed     san, sad, sbn, sbd;
            longint unsigned   am, ad_m, bm, bd_m, t1, t2, mag, den, g, x, y, r, half;
            bit                aneg, bneg, n1, n2, neg;
            status_t           st;
            logic [31:0]       rnum;
            logic [30:0]       rden;
            bit                lt, eq, gt;
            san = an; sad = ad; sbn = bn; sbd = bd;
            am = (san < 0) ? -san : san;
            ad_m = (sad < 0) ? -sad : sad;
            bm = (sbn < 0) ? -sbn : sbn;
            bd_m = (sbd < 0) ? -sbd : sbd;
            aneg = (an[31] != ad[31]) && am != 0;
            bneg = (bn[31] != bd[31]) && bm != 0;
            half = 64'd1 << 31;
            st = ST_OK; lt = 0; eq = 0; gt = 0;
            rnum = '0; rden = 31'd1;
            neg = 0; mag = 0; den = 1;
            if (cmd > CMD_CMP)
                st = ST_OK;
            else if (ad_m == 0 || (cmd != CMD_NORM && bd_m == 0))
                st = ST_ZERO_DEN;
            else if (cmd == CMD_DIV && bm == 0)
                st = ST_DIV_ZERO;
            else
            begin
                case (cmd)
                    CMD_NORM:
                    begin
                        neg = aneg; mag = am; den = ad_m;
                    end
                    CMD_MUL:
                    begin
                        neg = aneg != bneg; mag = am * bm; den = ad_m * bd_m;
                    end
                    CMD_DIV:
                    begin
                        neg = aneg != bneg; mag = am * bd_m; den = ad_m * bm;
                    end
                    default:
                    begin
                        // Subtract and compare negate B before the signed sum.
                        t1 = am * bd_m;
                        t2 = bm * ad_m;
                        n1 = aneg;
                        n2 = (cmd == CMD_ADD) ? bneg : (!bneg && bm != 0);
                        if (n1 == n2)
                        begin
                            mag = t1 + t2; neg = n1;
                        end
                        else if (t1 >= t2)
                        begin
                            mag = t1 - t2; neg = n1;
                        end
                        else
                        begin
                            mag = t2 - t1; neg = n2;
                        end
                        den = ad_m * bd_m;
                    end
                endcase
                if (mag == 0)
                begin
                    neg = 0; den = 1;
                end
                else
                begin
                    x = mag; y = den;
                    while (y != 0)
                    begin
                        r = x % y; x = y; y = r;
                    end
                    g = x;
                    mag = mag / g;
                    den = den / g;
                end
                if (cmd == CMD_CMP)
                begin
                    lt = mag != 0 && neg;
                    eq = mag == 0;
                    gt = mag != 0 && !neg;
                end
                else if (den > half - 1 || mag > (neg ? half : half - 1))
                    st = ST_OVERFLOW;
                else
                begin
                    rnum = neg ? 32'(-mag) : 32'(mag);
                    rden = den[30:0];
                end
            end
            return {4'b0, gt, eq, lt, st, rden, rnum};
        endfunction

        function void note_input(logic [135:0] data);
            pending_results.push_back(compute_result(data[2:0], data[34:3], data[66:35],
                                                     data[98:67], data[130:99]));
        endfunction

        function void check_result(logic [71:0] actual);
            logic [71:0] exp_r;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h", actual);
                return;
            end
            exp_r = pending_results.pop_front();
            if (actual[31:0] !== exp_r[31:0] || actual[62:32] !== exp_r[62:32]
                || actual[64:63] !== exp_r[64:63] || actual[65] !== exp_r[65]
                || actual[66] !== exp_r[66] || actual[67] !== exp_r[67])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: num %h/%h den %h/%h status %0d/%0d",
                              " lt %b/%b eq %b/%b gt %b/%b"},
                             exp_r[31:0], actual[31:0], exp_r[62:32], actual[62:32],
                             exp_r[64:63], actual[64:63], exp_r[65], actual[65],
                             exp_r[66], actual[66], exp_r[67], actual[67]);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    rational_scoreboard sb;
    int  results_seen;
    int  idle_cycles;
    bit  input_done;

    rational_arith_unit_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 150);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hffff_ffff;
            4, 5, 6: return 32'($signed($urandom_range(0, 2000)) - 1000);
            7: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(cmd_t cmd, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, bd, bn, ad, an, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(s_tdata);
    endtask

    // Receiver: random stalls, plus one long hold-off so the input backs up.
    initial
    begin
        int  hold;
        bit  pressure_done;
        hold = 0;
        pressure_done = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
                results_seen++;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && results_seen == 300)
            begin
                pressure_done = 1;
                hold = 8000;
                m_tready <= 1'b0;
            end
            else if (results_seen % 200 > 150)
                m_tready <= 1'b1;
            else
            begin
                hold = pick_gap();
                m_tready <= (hold == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 60000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] vals[6];
        sb = new();
        results_seen = 0;
        idle_cycles = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, field extremes, error paths, unknown codes.
        send_item(CMD_NORM, 32'd6, 32'hffff_fff7, 32'd0, 32'd0);
        send_item(CMD_NORM, 32'd0, 32'h8000_0000, 32'd5, 32'd7);
        send_item(CMD_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_item(CMD_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1);
        send_item(CMD_NORM, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd1);
        send_item(CMD_NORM, 32'd3, 32'd0, 32'd1, 32'd1);
        send_item(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(CMD_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_item(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
        send_item(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_item(CMD_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_item(CMD_SUB, 32'hffff_ffff, 32'd3, 32'd1, 32'hffff_fffd);
        send_item(CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_item(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_item(CMD_MUL, 32'd0, 32'd5, 32'hffff_ffff, 32'd7);
        send_item(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        send_item(CMD_DIV, 32'd3, 32'd4, 32'hffff_fffd, 32'd8);
        send_item(CMD_DIV, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
        send_item(CMD_DIV, 32'd1, 32'd0, 32'd0, 32'd1);
        send_item(CMD_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
        send_item(CMD_CMP, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
        send_item(CMD_CMP, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        send_item(CMD_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
        send_item(CMD_RSVD_LO, 32'd1, 32'd2, 32'd3, 32'd4);
        send_item(CMD_RSVD_HI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        repeat (1130)
        begin
            foreach (vals[i])
                vals[i] = pick_value();
            // Mostly nonzero denominators so the arithmetic paths dominate.
            if (vals[1] == 0 && $urandom_range(0, 3) != 0)
                vals[1] = 32'd1;
            if (vals[3] == 0 && $urandom_range(0, 3) != 0)
                vals[3] = 32'hffff_ffff;
            send_item(($urandom_range(0, 19) == 0)
                          ? 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI))
                          : 3'($urandom_range(CMD_NORM, CMD_CMP)),
                      vals[0], vals[1], vals[2], vals[3]);
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
